// ----- design/taubin_uniform_mesh_smoother_unit_assert.svh -----
// Assertion macros for the Taubin mesh smoother.
// Each macro expects clk and rst_n in the scope of its use.
`ifndef TAUBIN_UNIFORM_MESH_SMOOTHER_UNIT_ASSERT_SVH
`define TAUBIN_UNIFORM_MESH_SMOOTHER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TUMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TUMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tums_pkg.sv -----
// Shared types, field widths, codes and helpers of the Taubin mesh smoother.
// No dependencies.
`timescale 1ns / 1ps

package tums_pkg;

    localparam int MAX_NODES_DEF  = 1024;
    localparam int MAX_DEGREE_DEF = 8;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 10;
    localparam int COORD_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int PAIRS_W    = 10;
    localparam int NCOUNT_W   = 11;
    localparam int STATUS_W   = 2;
    localparam int DEG_W      = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 96;
    localparam int POS_W      = 3 * COORD_W;
    localparam int LANES      = 3;
    localparam int SUM_W      = 37;
    localparam int PROD_W     = 48;
    localparam int FRAC_SHIFT = 14;
    localparam int DIV_CNT_W  = 6;
    localparam int PASS_W     = PAIRS_W + 1;

    localparam logic [GAIN_W-1:0]   LAMBDA_RST = 16'd10333;
    localparam logic [GAIN_W-1:0]   MU_RST     = 16'hD4EC;
    localparam logic [PAIRS_W-1:0]  PAIRS_RST  = 10'd50;
    localparam logic [NCOUNT_W-1:0] COUNT_RST  = 11'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LAMBDA = 2'd0,
        REG_MU     = 2'd1,
        REG_PAIRS  = 2'd2,
        REG_COUNT  = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_DEG,
        S_DEGW,
        S_NB,
        S_NBW,
        S_POSW,
        S_DIVGO,
        S_DIV,
        S_UPD_RD,
        S_UPD_WAIT,
        S_UPD_MUL,
        S_UPD_ACC,
        S_UPD_WR
    } state_t;

    typedef struct packed {
        logic                            start;
        logic [DEG_W-1:0]                divisor;
        logic [LANES-1:0][SUM_W-1:0]     dividend;
    } div_req_t;

    typedef struct packed {
        logic                            done;
        logic [LANES-1:0][SUM_W-1:0]     quot;
    } div_rsp_t;

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
        lo = {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
        if (v > hi)
            return hi[COORD_W-1:0];
        else if (v < lo)
            return lo[COORD_W-1:0];
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

// ----- design/taubin_uniform_mesh_smoother_unit.sv -----
// Top level of the Taubin lambda/mu uniform Laplacian mesh smoother.
// Depends on tums_pkg, tums_ram, tums_div and the assertion macro header.
//
//  channel   | signals                        | moves
//  ----------+--------------------------------+------------------------------------
//  slave     | s_tvalid s_tready s_tdata/user | one command request per handshake
//  master    | m_tvalid m_tready m_tdata/user | one status/position result per request
//  config    | cfg_we cfg_addr cfg_wdata      | register write, no wait
//
// Write completes in the execute state; read and add-neighbor add a read-wait
// state; the result then waits in the output register, and no request is taken
// until it leaves. Run: per pass, each node reads its degree and its neighbors'
// positions, the divider averages the offsets (not if it has none), then every node is
// updated; 2*iteration_pairs passes. After reset a clearing pass zeros degree memory.
`timescale 1ns / 1ps

module taubin_uniform_mesh_smoother_unit #(
    parameter int MAX_NODES  = tums_pkg::MAX_NODES_DEF,
    parameter int MAX_DEGREE = tums_pkg::MAX_DEGREE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // node_index[9:0], pos_x[41:10], pos_y[73:42], pos_z[105:74],
    // neighbor_index[115:106], zero fill above
    input  logic [tums_pkg::IN_DATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [tums_pkg::CMD_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [tums_pkg::OUT_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [tums_pkg::STATUS_W-1:0]   m_tuser,
    input  logic                            cfg_we,
    input  logic [tums_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tums_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import tums_pkg::*;

    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int SLOT_W    = $clog2(MAX_DEGREE);
    localparam int NBR_DEPTH = MAX_NODES * (2 ** SLOT_W);

    state_t state_reg, state_next;

    logic [GAIN_W-1:0]   lambda_reg;
    logic [GAIN_W-1:0]   mu_reg;
    logic [PAIRS_W-1:0]  pairs_reg;
    logic [NCOUNT_W-1:0] count_reg;

    cmd_t               cmd_reg;
    logic [IDX_W-1:0]   node_reg;
    logic [IDX_W-1:0]   nb_reg;
    logic [POS_W-1:0]   wpos_reg;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [NODE_W-1:0]  clr_reg;
    logic [CNT_W-1:0]   i_reg;
    logic [DEG_W-1:0]   j_reg;
    logic [DEG_W-1:0]   deg_reg;
    logic [PASS_W-1:0]  pass_reg;
    logic [1:0]         ax_reg;
    logic signed [COORD_W-1:0] self_reg [LANES];
    logic signed [COORD_W-1:0] pcur_reg [LANES];
    logic signed [COORD_W-1:0] dsp_reg  [LANES];
    logic [COORD_W-1:0]        new_reg  [LANES];
    logic signed [SUM_W-1:0]   acc_reg  [LANES];
    logic signed [PROD_W-1:0]  prod_reg;

    // memory ports
    logic                pos_we,  disp_we,  nbr_we,  deg_we;
    logic [NODE_W-1:0]   pos_waddr, pos_raddr, disp_waddr, deg_waddr, deg_raddr;
    logic [POS_W-1:0]    pos_wdata, pos_rdata, disp_wdata, disp_rdata;
    logic [NODE_W+SLOT_W-1:0] nbr_waddr, nbr_raddr;
    logic [NODE_W-1:0]   nbr_wdata, nbr_rdata;
    logic [DEG_W-1:0]    deg_wdata, deg_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [CNT_W-1:0]    n_act;
    logic                node_ok, nb_ok, last_node, last_pass, item_acc;
    logic                res_valid;
    status_t             res_status;
    logic [OUT_DATA_W-1:0] res_data;
    logic signed [GAIN_W-1:0] gain_sel;
    logic signed [SUM_W-1:0]  upd_sum;

    assign n_act = (32'(count_reg) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(count_reg);
    assign node_ok   = 32'(node_reg) < 32'(n_act);
    assign nb_ok     = 32'(nb_reg) < 32'(n_act);
    assign last_node = CNT_W'(i_reg + 1'b1) == n_act;
    assign last_pass = PASS_W'(pass_reg + 1'b1) == {pairs_reg, 1'b0};
    assign item_acc  = s_tvalid && s_tready;
    assign gain_sel  = pass_reg[0] ? $signed(mu_reg) : $signed(lambda_reg);
    assign upd_sum   = SUM_W'(pcur_reg[ax_reg]) + SUM_W'(prod_reg >>> FRAC_SHIFT);

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    tums_ram #(.WIDTH(POS_W), .DEPTH(MAX_NODES)) u_pos_ram (
        .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .raddr(pos_raddr), .rdata(pos_rdata)
    );

    tums_ram #(.WIDTH(POS_W), .DEPTH(MAX_NODES)) u_disp_ram (
        .clk(clk), .we(disp_we), .waddr(disp_waddr), .wdata(disp_wdata),
        .raddr(NODE_W'(i_reg)), .rdata(disp_rdata)
    );

    tums_ram #(.WIDTH(NODE_W), .DEPTH(NBR_DEPTH)) u_nbr_ram (
        .clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
        .raddr(nbr_raddr), .rdata(nbr_rdata)
    );

    tums_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
        .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rdata)
    );

    tums_div u_div (
        .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
    );

    always_comb
    begin
        div_req.start   = (state_reg == S_DIVGO);
        div_req.divisor = deg_reg;
        for (int l = 0; l < LANES; l++)
        begin
            div_req.dividend[l] = acc_reg[l];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == NODE_W'(MAX_NODES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (item_acc)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_READ:  state_next = node_ok ? S_RDWAIT : S_IDLE;
                    CMD_ADD:   state_next = (node_ok && nb_ok) ? S_RDWAIT : S_IDLE;
                    CMD_RUN:   state_next = (n_act == '0 || pairs_reg == '0) ? S_IDLE : S_DEG;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_RDWAIT:   state_next = S_IDLE;
            S_DEG:      state_next = S_DEGW;
            S_DEGW:
            begin
                if (deg_rdata != '0)
                    state_next = S_NB;
                else
                    state_next = last_node ? S_UPD_RD : S_DEG;
            end
            S_NB:       state_next = S_NBW;
            S_NBW:      state_next = S_POSW;
            S_POSW:     state_next = (DEG_W'(j_reg + 1'b1) == deg_reg) ? S_DIVGO : S_NB;
            S_DIVGO:    state_next = S_DIV;
            S_DIV:
            begin
                if (div_rsp.done)
                    state_next = last_node ? S_UPD_RD : S_DEG;
            end
            S_UPD_RD:   state_next = S_UPD_WAIT;
            S_UPD_WAIT: state_next = S_UPD_MUL;
            S_UPD_MUL:  state_next = S_UPD_ACC;
            S_UPD_ACC:  state_next = (ax_reg == 2'd2) ? S_UPD_WR : S_UPD_MUL;
            S_UPD_WR:
            begin
                if (!last_node)
                    state_next = S_UPD_RD;
                else
                    state_next = last_pass ? S_IDLE : S_DEG;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // memory controls and result
    always_comb
    begin
        pos_we     = 1'b0;
        pos_waddr  = NODE_W'(i_reg);
        pos_wdata  = {new_reg[2], new_reg[1], new_reg[0]};
        pos_raddr  = NODE_W'(i_reg);
        disp_we    = 1'b0;
        disp_waddr = NODE_W'(i_reg);
        disp_wdata = '0;
        nbr_we     = 1'b0;
        nbr_waddr  = {NODE_W'(node_reg), deg_rdata[SLOT_W-1:0]};
        nbr_wdata  = NODE_W'(nb_reg);
        nbr_raddr  = {i_reg[NODE_W-1:0], j_reg[SLOT_W-1:0]};
        deg_we     = 1'b0;
        deg_waddr  = NODE_W'(node_reg);
        deg_wdata  = DEG_W'(deg_rdata + 1'b1);
        deg_raddr  = NODE_W'(i_reg);
        res_valid  = 1'b0;
        res_status = STATUS_OK;
        res_data   = '0;
        case (state_reg)
            S_CLEAR:
            begin
                deg_we    = 1'b1;
                deg_waddr = clr_reg;
                deg_wdata = '0;
            end
            S_EXEC:
            begin
                pos_raddr = NODE_W'(node_reg);
                deg_raddr = NODE_W'(node_reg);
                case (cmd_reg)
                    CMD_WRITE:
                    begin
                        pos_we     = node_ok;
                        pos_waddr  = NODE_W'(node_reg);
                        pos_wdata  = wpos_reg;
                        res_valid  = 1'b1;
                        res_status = node_ok ? STATUS_OK : STATUS_RANGE;
                    end
                    CMD_READ:
                    begin
                        res_valid  = !node_ok;
                        res_status = STATUS_RANGE;
                    end
                    CMD_ADD:
                    begin
                        res_valid  = !(node_ok && nb_ok);
                        res_status = STATUS_RANGE;
                    end
                    default:
                    begin
                        res_valid = (n_act == '0 || pairs_reg == '0);
                    end
                endcase
            end
            S_RDWAIT:
            begin
                res_valid = 1'b1;
                if (cmd_reg == CMD_READ)
                begin
                    res_data = pos_rdata;
                end
                else if (deg_rdata >= DEG_W'(MAX_DEGREE))
                begin
                    res_status = STATUS_FULL;
                end
                else
                begin
                    nbr_we = 1'b1;
                    deg_we = 1'b1;
                end
            end
            S_DEGW:
            begin
                // isolated node: zero displacement
                disp_we = (deg_rdata == '0);
            end
            S_NBW:
            begin
                pos_raddr = nbr_rdata;
            end
            S_DIV:
            begin
                disp_we    = div_rsp.done;
                disp_wdata = {sat_coord($signed(div_rsp.quot[2])),
                              sat_coord($signed(div_rsp.quot[1])),
                              sat_coord($signed(div_rsp.quot[0]))};
            end
            S_UPD_WR:
            begin
                pos_we    = 1'b1;
                res_valid = last_node && last_pass;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            lambda_reg    <= LAMBDA_RST;
            mu_reg        <= MU_RST;
            pairs_reg     <= PAIRS_RST;
            count_reg     <= COUNT_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (res_valid)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_addr))
                    REG_LAMBDA: lambda_reg <= cfg_wdata;
                    REG_MU:     mu_reg     <= cfg_wdata;
                    REG_PAIRS:  pairs_reg  <= cfg_wdata[PAIRS_W-1:0];
                    REG_COUNT:  count_reg  <= cfg_wdata[NCOUNT_W-1:0];
                    default:    pairs_reg  <= pairs_reg;
                endcase
            end
        end
    end

    // payload and loop registers
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_status_reg <= res_status;
            out_data_reg   <= res_data;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    cmd_reg  <= cmd_t'(s_tuser);
                    node_reg <= s_tdata[9:0];
                    wpos_reg <= s_tdata[105:10];
                    nb_reg   <= s_tdata[115:106];
                end
            end
            S_EXEC:
            begin
                i_reg    <= '0;
                pass_reg <= '0;
            end
            S_DEGW:
            begin
                deg_reg <= deg_rdata;
                j_reg   <= '0;
                for (int l = 0; l < LANES; l++)
                begin
                    self_reg[l] <= $signed(pos_rdata[l*COORD_W +: COORD_W]);
                    acc_reg[l]  <= '0;
                end
                if (deg_rdata == '0)
                    i_reg <= last_node ? '0 : CNT_W'(i_reg + 1'b1);
            end
            S_POSW:
            begin
                j_reg <= DEG_W'(j_reg + 1'b1);
                for (int l = 0; l < LANES; l++)
                begin
                    acc_reg[l] <= acc_reg[l]
                                + SUM_W'($signed(pos_rdata[l*COORD_W +: COORD_W]))
                                - SUM_W'(self_reg[l]);
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                    i_reg <= last_node ? '0 : CNT_W'(i_reg + 1'b1);
            end
            S_UPD_WAIT:
            begin
                ax_reg <= '0;
                for (int l = 0; l < LANES; l++)
                begin
                    pcur_reg[l] <= $signed(pos_rdata[l*COORD_W +: COORD_W]);
                    dsp_reg[l]  <= $signed(disp_rdata[l*COORD_W +: COORD_W]);
                end
            end
            S_UPD_MUL:
            begin
                prod_reg <= PROD_W'(gain_sel) * PROD_W'(dsp_reg[ax_reg]);
            end
            S_UPD_ACC:
            begin
                new_reg[ax_reg] <= sat_coord(upd_sum);
                ax_reg          <= ax_reg + 1'b1;
            end
            S_UPD_WR:
            begin
                if (last_node)
                begin
                    i_reg    <= '0;
                    pass_reg <= PASS_W'(pass_reg + 1'b1);
                end
                else
                begin
                    i_reg <= CNT_W'(i_reg + 1'b1);
                end
            end
            default:
            begin
                ax_reg <= ax_reg;
            end
        endcase
    end

`include "taubin_uniform_mesh_smoother_unit_assert.svh"

    `TUMS_ASSERT_NOW(a_one_request, s_tready, !m_tvalid, "request taken while result pending")
    `TUMS_ASSERT_NEXT(a_accept_busy, item_acc, !s_tready, "second request taken at once")
    `TUMS_ASSERT_NOW(a_deg_bound, deg_we, deg_wdata <= DEG_W'(MAX_DEGREE), "degree overflow")
    `TUMS_ASSERT_NOW(a_div_state, div_rsp.done, state_reg == S_DIV, "stray divider result")

endmodule

// ----- design/tums_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tums_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/tums_div.sv -----
// Three-lane restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on tums_pkg.
`timescale 1ns / 1ps

module tums_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tums_pkg::div_req_t req,
    output tums_pkg::div_rsp_t rsp
);

    import tums_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEG_W-1:0]     d_reg;
    logic [SUM_W-1:0]     q_reg   [LANES];
    logic [DEG_W-1:0]     r_reg   [LANES];
    logic                 neg_reg [LANES];

    logic [SUM_W-1:0]     q_next  [LANES];
    logic [DEG_W-1:0]     r_next  [LANES];
    logic [SUM_W-1:0]     mag     [LANES];
    logic [DEG_W:0]       trial   [LANES];
    logic                 fit     [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            mag[l]    = req.dividend[l][SUM_W-1] ? (~req.dividend[l] + 1'b1)
                                                 : req.dividend[l];
            trial[l]  = {r_reg[l], q_reg[l][SUM_W-1]};
            fit[l]    = trial[l] >= {1'b0, d_reg};
            r_next[l] = fit[l] ? DEG_W'(trial[l] - {1'b0, d_reg}) : trial[l][DEG_W-1:0];
            q_next[l] = {q_reg[l][SUM_W-2:0], fit[l]};
            rsp.quot[l] = neg_reg[l] ? (~q_reg[l] + 1'b1) : q_reg[l];
        end
        rsp.done = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            d_reg <= req.divisor;
            for (int l = 0; l < LANES; l++)
            begin
                q_reg[l]   <= mag[l];
                r_reg[l]   <= '0;
                neg_reg[l] <= req.dividend[l][SUM_W-1];
            end
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                q_reg[l] <= q_next[l];
                r_reg[l] <= r_next[l];
            end
        end
    end

endmodule

// ----- bench/taubin_uniform_mesh_smoother_unit_tb.sv -----
// Self-checking bench for the Taubin lambda/mu mesh smoother: directed table, then random
// phases across gain, pass-count and node-count settings, checked by a local predictor and the table's answers.
// Depends on tums_pkg and taubin_uniform_mesh_smoother_unit.
`timescale 1ns / 1ps

module taubin_uniform_mesh_smoother_unit_tb;
    import tums_pkg::*;

    localparam int NODES = 1024;
    localparam int DEG_MAX = 8;
    localparam int LIMIT = 3000000;

    typedef struct {
        status_t         status;
        logic [31:0]     x;
        logic [31:0]     y;
        logic [31:0]     z;
    } answer_t;

    typedef struct {
        cmd_t            cmd;
        logic [9:0]      node;
        logic [31:0]     x;
        logic [31:0]     y;
        logic [31:0]     z;
        logic [9:0]      nb;
        bit              typed;
        answer_t         ans;
    } row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic [CMD_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    taubin_uniform_mesh_smoother_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // mirror of the mesh memories and registers
    logic signed [31:0] mesh_pos [NODES][3];
    logic signed [31:0] mesh_disp [NODES][3];
    logic [9:0] nb_list [NODES][DEG_MAX];
    int unsigned nb_deg [NODES];
    bit pos_valid [NODES];
    logic [15:0] lambda_q, mu_q;
    logic [9:0] pair_cnt;
    logic [10:0] node_cnt;

    answer_t pending_answers [$];
    row_t directed_rows [$];
    int send_idle, recv_idle;
    int errors, checked, requests, runs_done;
    int hold_req, hold_seen, hold_left;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("taubin_uniform_mesh_smoother_unit_tb NOT OK");
            $finish;
        end
    end

    // result side: random stalls, long hold on request, compare oldest expectation
    always @(posedge clk)
    begin
        answer_t e;
        if (m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result with nothing expected: status %0d", m_tuser);
                errors++;
            end
            else
            begin
                e = pending_answers.pop_front();
                checked++;
                if (m_tuser !== e.status)
                begin
                    $error("status expected %0d got %0d", e.status, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] !== e.x)
                begin
                    $error("out_x expected %h got %h", e.x, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== e.y)
                begin
                    $error("out_y expected %h got %h", e.y, m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] !== e.z)
                begin
                    $error("out_z expected %h got %h", e.z, m_tdata[95:64]);
                    errors++;
                end
            end
        end
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic int unsigned live_nodes();
        return (node_cnt > NODES) ? NODES : node_cnt;
    endfunction

    function automatic void smooth_once(longint gain);
        int unsigned n;
        longint acc;
        n = live_nodes();
        for (int i = 0; i < n; i++)
            for (int a = 0; a < 3; a++)
            begin
                acc = 0;
                for (int j = 0; j < nb_deg[i]; j++)
                    acc += longint'(mesh_pos[nb_list[i][j]][a]) - longint'(mesh_pos[i][a]);
                mesh_disp[i][a] = (nb_deg[i] == 0) ? 32'sd0 : clamp32(acc / longint'(nb_deg[i]));
            end
        for (int i = 0; i < n; i++)
            for (int a = 0; a < 3; a++)
                mesh_pos[i][a] = clamp32(longint'(mesh_pos[i][a])
                                         + ((gain * longint'(mesh_disp[i][a])) >>> 14));
    endfunction

    function automatic answer_t smoother_answer(row_t r);
        answer_t o;
        int unsigned n;
        n = live_nodes();
        o = '{STATUS_OK, 32'd0, 32'd0, 32'd0};
        case (r.cmd)
            CMD_WRITE:
                if (r.node >= n)
                    o.status = STATUS_RANGE;
                else
                begin
                    mesh_pos[r.node][0] = r.x;
                    mesh_pos[r.node][1] = r.y;
                    mesh_pos[r.node][2] = r.z;
                    pos_valid[r.node] = 1'b1;
                end
            CMD_ADD:
                if (r.node >= n || r.nb >= n)
                    o.status = STATUS_RANGE;
                else if (nb_deg[r.node] >= DEG_MAX)
                    o.status = STATUS_FULL;
                else
                begin
                    nb_list[r.node][nb_deg[r.node]] = r.nb;
                    nb_deg[r.node]++;
                end
            CMD_RUN:
                for (int p = 0; p < 2 * pair_cnt; p++)
                    smooth_once(p[0] ? longint'($signed(mu_q)) : longint'($signed(lambda_q)));
            default:
                if (r.node >= n)
                    o.status = STATUS_RANGE;
                else
                begin
                    o.x = mesh_pos[r.node][0];
                    o.y = mesh_pos[r.node][1];
                    o.z = mesh_pos[r.node][2];
                end
        endcase
        return o;
    endfunction

    // a run may only touch positions that were written
    function automatic bit run_allowed();
        for (int i = 0; i < live_nodes(); i++)
        begin
            if (!pos_valid[i])
                return 0;
            for (int j = 0; j < nb_deg[i]; j++)
                if (!pos_valid[nb_list[i][j]])
                    return 0;
        end
        return 1;
    endfunction

    task automatic send_request(row_t r);
        answer_t predicted;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.cmd;
        s_tdata <= {4'd0, r.nb, r.z, r.y, r.x, r.node};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = smoother_answer(r);
        if (r.typed)
            predicted = r.ans;
        pending_answers.insert(pending_answers.size(), predicted);
        requests++;
        if (r.cmd == CMD_RUN)
            runs_done++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(logic [15:0] l, logic [15:0] m, logic [9:0] p, logic [10:0] c);
        cfg_we <= 1'b1;
        cfg_addr <= REG_LAMBDA;
        cfg_wdata <= l;
        @(posedge clk);
        cfg_addr <= REG_MU;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_addr <= REG_PAIRS;
        cfg_wdata <= {6'd0, p};
        @(posedge clk);
        cfg_addr <= REG_COUNT;
        cfg_wdata <= {5'd0, c};
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        lambda_q = l;
        mu_q = m;
        pair_cnt = p;
        node_cnt = c;
    endtask

    task automatic add_row(cmd_t c, int node, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           int nb, bit typed = 0, status_t st = STATUS_OK,
                           logic [31:0] ex = 0, logic [31:0] ey = 0, logic [31:0] ez = 0);
        row_t r;
        r.cmd = c;
        r.node = 10'(node);
        r.x = x;
        r.y = y;
        r.z = z;
        r.nb = 10'(nb);
        r.typed = typed;
        r.ans = '{st, ex, ey, ez};
        directed_rows.insert(directed_rows.size(), r);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom;
            default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic int pick_node_out(int n);
        return (n >= NODES) ? $urandom_range(NODES - 1) : $urandom_range(NODES - 1, n);
    endfunction

    function automatic row_t random_row(bit may_run);
        row_t r;
        int n, k;
        n = live_nodes();
        r.typed = 0;
        r.x = pick_coord();
        r.y = pick_coord();
        r.z = pick_coord();
        r.nb = 10'($urandom);
        r.node = 10'($urandom);
        k = $urandom_range(99);
        if (k >= 95 && may_run && run_allowed())
            r.cmd = CMD_RUN;
        else if (k >= 60 && k < 95)
        begin
            r.cmd = CMD_READ;
            if (n == 0 || $urandom_range(9) == 0)
                r.node = 10'(pick_node_out(n));
            else
                r.node = 10'($urandom_range(n - 1));
            // never read a node that was not written
            if (r.node < n && !pos_valid[r.node])
                r.cmd = CMD_WRITE;
        end
        else if (k >= 35 && k < 60 && n > 0)
        begin
            r.cmd = CMD_ADD;
            r.node = 10'($urandom_range(n - 1));
            r.nb = 10'($urandom_range(n - 1));
            if ($urandom_range(9) == 0)
                r.node = 10'(pick_node_out(n));
            else if ($urandom_range(9) == 0)
                r.nb = 10'(pick_node_out(n));
        end
        else
        begin
            r.cmd = CMD_WRITE;
            if (n == 0 || $urandom_range(9) == 0)
                r.node = 10'(pick_node_out(n));
            else
                r.node = 10'($urandom_range(n - 1));
        end
        return r;
    endfunction

    task automatic random_phase(logic [15:0] l, logic [15:0] m, logic [9:0] p, logic [10:0] c,
                                int s_idle, int r_idle, int count, int run_budget);
        row_t r;
        drain();
        set_config(l, m, p, c);
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int i = 0; i < count; i++)
        begin
            r = random_row(run_budget > 0);
            if (r.cmd == CMD_RUN)
                run_budget--;
            send_request(r);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_WRITE;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_LAMBDA;
        cfg_wdata = '0;
        errors = 0;
        checked = 0;
        requests = 0;
        runs_done = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        cycles = 0;
        send_idle = 0;
        recv_idle = 0;
        lambda_q = LAMBDA_RST;
        mu_q = MU_RST;
        pair_cnt = PAIRS_RST;
        node_cnt = COUNT_RST;
        for (int i = 0; i < NODES; i++)
        begin
            nb_deg[i] = 0;
            pos_valid[i] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // node count is zero after reset: everything is out of range
        add_row(CMD_WRITE, 0, 32'h1, 32'h2, 32'h3, 0, 1, STATUS_RANGE);
        add_row(CMD_READ, 1023, 0, 0, 0, 1023, 1, STATUS_RANGE);
        foreach (directed_rows[i])
            send_request(directed_rows[i]);
        directed_rows.delete();
        drain();
        set_config(LAMBDA_RST, MU_RST, 10'd1, 11'd4);

        add_row(CMD_WRITE, 0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 0, 1, STATUS_OK);
        add_row(CMD_WRITE, 4, 32'h5, 32'h5, 32'h5, 0, 1, STATUS_RANGE);
        add_row(CMD_WRITE, 1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000, 0);
        add_row(CMD_WRITE, 2, 32'h00010000, 32'hFFFE0000, 32'h00008000, 0);
        add_row(CMD_WRITE, 3, 32'h00030000, 32'h00000001, 32'hFFFFFFFF, 0);
        add_row(CMD_READ, 0, 0, 0, 0, 0, 1, STATUS_OK, 32'h7FFFFFFF, 32'h80000000, 32'h0);
        add_row(CMD_READ, 4, 0, 0, 0, 0, 1, STATUS_RANGE);
        add_row(CMD_ADD, 0, 0, 0, 0, 4, 1, STATUS_RANGE);
        add_row(CMD_ADD, 1023, 0, 0, 0, 1, 1, STATUS_RANGE);
        for (int i = 0; i < 8; i++)
            add_row(CMD_ADD, 0, 0, 0, 0, 1, 1, STATUS_OK);
        // list is full now
        add_row(CMD_ADD, 0, 0, 0, 0, 2, 1, STATUS_FULL);
        add_row(CMD_ADD, 1, 0, 0, 0, 0, 1, STATUS_OK);
        add_row(CMD_ADD, 3, 0, 0, 0, 1, 1, STATUS_OK);
        add_row(CMD_ADD, 3, 0, 0, 0, 2, 1, STATUS_OK);
        // node 2 keeps no neighbors
        add_row(CMD_RUN, 0, 0, 0, 0, 0, 1, STATUS_OK);
        for (int i = 0; i < 4; i++)
            add_row(CMD_READ, i, 0, 0, 0, 0);
        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        // receiver holds off while requests keep coming
        drain();
        hold_req = 1;
        random_phase(16'd10333, 16'hD4EC, 10'd2, 11'd8, 15, 47, 110, 6);
        random_phase(16'h8000, 16'h7FFF, 10'd1, 11'd12, 47, 15, 110, 6);
        random_phase(16'h7FFF, 16'h8000, 10'd3, 11'd6, 0, 0, 110, 6);
        random_phase(16'd5000, -16'sd5200, 10'd0, 11'd16, 15, 47, 80, 6);
        random_phase(16'($urandom), 16'($urandom), 10'd1023, 11'd1, 47, 15, 60, 1);
        random_phase(16'($urandom), 16'($urandom), 10'd2, 11'd1024, 0, 0, 80, 0);
        random_phase(16'd8000, -16'sd8200, 10'd1, 11'd0, 15, 47, 30, 2);
        drain();
        repeat (50) @(posedge clk);

        $display("covered %0d requests (%0d smoothing runs), %0d results checked,",
                 requests, runs_done, checked);
        $display("over seven register settings including gain, pass and node-count extremes");
        if (errors == 0 && pending_answers.size() == 0)
            $display("taubin_uniform_mesh_smoother_unit_tb OK");
        else
            $display("taubin_uniform_mesh_smoother_unit_tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/tums_pkg.sv
design/tums_ram.sv
design/tums_div.sv
design/taubin_uniform_mesh_smoother_unit.sv
bench/taubin_uniform_mesh_smoother_unit_tb.sv
